### rtl/bilinear_upscale_2x_unit_assert.svh
// Assertion macros for the 2x bilinear upscaler.
// Needs no package; included by the top level only.
`ifndef BILINEAR_UPSCALE_2X_UNIT_ASSERT_SVH
`define BILINEAR_UPSCALE_2X_UNIT_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define BU2X_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("bu2x check failed");

// Next-cycle implication, checked while out of reset.
`define BU2X_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("bu2x check failed");

`endif

### rtl/bu2x_pkg.sv
// Shared types and constants of the 2x bilinear upscaler.
// No dependencies; used by all modules of the block except bu2x_ram.
package bu2x_pkg;

	// Counter and register widths.
	localparam int CNT_BITS = 10;
	localparam int CFG_BITS = 11;
	localparam logic [CFG_BITS-1:0] MAX_ROWS = 11'd1024;

	// Configuration register indexes.
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_MODE   = 2'd2;

	// Block slots an item can cause, in emission order.
	localparam logic [1:0] SLOT_UP_LEFT = 2'd0; // block (row-1, col-1)
	localparam logic [1:0] SLOT_LEFT    = 2'd1; // block (row,   col-1)
	localparam logic [1:0] SLOT_UP      = 2'd2; // block (row-1, col)
	localparam logic [1:0] SLOT_SELF    = 2'd3; // block (row,   col)

	// Neighborhood pixel positions handed to the output stage.
	localparam int PIX_PREV_UP = 0; // previous column, row above
	localparam int PIX_UP      = 1; // this column, row above
	localparam int PIX_PREV    = 2; // previous column, this row
	localparam int PIX_CUR     = 3; // this pixel

	// Which blocks an item causes and where the item sits.
	typedef struct packed {
		logic [3:0]          mask;
		logic [CNT_BITS-1:0] row;
		logic [CNT_BITS-1:0] col;
	} bu2x_hdr_t;

endpackage

### rtl/bu2x_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module bu2x_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and read-old-data on the same edge.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/bu2x_ctrl.sv
// Raster counters, line memory access and neighborhood registers.
// Depends on bu2x_pkg and bu2x_ram.
module bu2x_ctrl #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [bu2x_pkg::CFG_BITS-1:0]       width_eff,
	input  logic [bu2x_pkg::CFG_BITS-1:0]       height_eff,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [PIXEL_BITS-1:0]               pixel_in,
	input  logic                                s2_free,
	output logic                                load,
	output bu2x_pkg::bu2x_hdr_t                 hdr,
	output logic [3:0][PIXEL_BITS-1:0]          pix
);

	localparam int AW = $clog2(MAX_WIDTH);

	logic [bu2x_pkg::CNT_BITS-1:0] col_q, row_q;
	logic                          last_col, last_row, accept, col_inr;
	logic [3:0]                    mask_in;
	logic [AW-1:0]                 rd_addr, wr_addr;
	logic                          wr_en;
	logic [PIXEL_BITS-1:0]         rd_data, above;

	logic                          v_s1, inr_s1, fwd_s1;
	logic [3:0]                    mask_s1;
	logic [bu2x_pkg::CNT_BITS-1:0] row_s1, col_s1;
	logic [PIXEL_BITS-1:0]         px_s1, fwdpx_s1;
	logic                          s1_adv;

	logic [PIXEL_BITS-1:0]         prev_up_q, prev_q;

	// Position decode for the pixel now at the input.
	assign last_col = ({1'b0, col_q} + 11'd1) >= width_eff;
	assign last_row = ({1'b0, row_q} + 11'd1) >= height_eff;
	assign col_inr  = 32'(col_q) < 32'(MAX_WIDTH);
	assign mask_in[bu2x_pkg::SLOT_UP_LEFT] = (row_q != '0) && (col_q != '0);
	assign mask_in[bu2x_pkg::SLOT_LEFT]    = last_row && (col_q != '0);
	assign mask_in[bu2x_pkg::SLOT_UP]      = last_col && (row_q != '0);
	assign mask_in[bu2x_pkg::SLOT_SELF]    = last_col && last_row;

	// Stage 1 retires when it has no block or the output stage takes it.
	assign s1_adv   = v_s1 && ((mask_s1 == '0) || s2_free);
	assign in_ready = !v_s1 || s1_adv;
	assign accept   = in_valid && in_ready;
	assign load     = v_s1 && (mask_s1 != '0) && s2_free;

	// Line memory: read at accept, write back when stage 1 retires.
	assign rd_addr = AW'(col_q);
	assign wr_addr = AW'(col_s1);
	assign wr_en   = s1_adv && inr_s1;

	bu2x_ram #(
		.WIDTH(PIXEL_BITS),
		.DEPTH(MAX_WIDTH)
	) u_line (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(px_s1),
		.re   (accept),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// Pixel above: forwarded when the write-back hit the same entry; zero beyond the line memory.
	always_comb begin
		if (!inr_s1) begin
			above = '0;
		end else if (fwd_s1) begin
			above = fwdpx_s1;
		end else begin
			above = rd_data;
		end
	end

	// Raster counters, wrapping at the end of a row and of a frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + 10'd1;
			end else begin
				col_q <= col_q + 10'd1;
			end
		end
	end

	// Stage 1 valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (s1_adv) begin
			v_s1 <= 1'b0;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			mask_s1  <= mask_in;
			row_s1   <= row_q;
			col_s1   <= col_q;
			px_s1    <= pixel_in;
			inr_s1   <= col_inr;
			fwd_s1   <= wr_en && (wr_addr == rd_addr);
			fwdpx_s1 <= px_s1;
		end
	end

	// Left neighbors in this row and the row above.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_up_q <= '0;
			prev_q    <= '0;
		end else if (s1_adv) begin
			prev_up_q <= above;
			prev_q    <= px_s1;
		end
	end

	assign hdr.mask = mask_s1;
	assign hdr.row  = row_s1;
	assign hdr.col  = col_s1;
	assign pix[bu2x_pkg::PIX_PREV_UP] = prev_up_q;
	assign pix[bu2x_pkg::PIX_UP]      = above;
	assign pix[bu2x_pkg::PIX_PREV]    = prev_q;
	assign pix[bu2x_pkg::PIX_CUR]     = px_s1;

endmodule

### rtl/bu2x_emit.sv
// Output stage: holds one item's blocks and sends them one per cycle while out_ready is high.
// Depends on bu2x_pkg.
module bu2x_emit #(
	parameter int PIXEL_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  bu2x_pkg::bu2x_hdr_t                 hdr,
	input  logic [3:0][PIXEL_BITS-1:0]          pix,
	input  logic                                mode,
	output logic                                s2_free,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [bu2x_pkg::CNT_BITS-1:0]       src_row,
	output logic [bu2x_pkg::CNT_BITS-1:0]       src_col,
	output logic [PIXEL_BITS-1:0]               top_left,
	output logic [PIXEL_BITS-1:0]               top_right,
	output logic [PIXEL_BITS-1:0]               bottom_left,
	output logic [PIXEL_BITS-1:0]               bottom_right,
	output logic                                run_last
);

	logic [3:0]                    mask_s2, pop;
	logic [bu2x_pkg::CNT_BITS-1:0] row_s2, col_s2;
	logic [3:0][PIXEL_BITS-1:0]    pix_s2;
	logic [1:0]                    slot;
	logic [PIXEL_BITS-1:0]         pa, pb, pc, pd;
	logic [PIXEL_BITS:0]           sum_ab, sum_ac;
	logic [PIXEL_BITS+1:0]         sum_all;

	// Remaining blocks after the current one goes out.
	assign pop       = mask_s2 & (mask_s2 - 4'd1);
	assign out_valid = mask_s2 != '0;
	assign s2_free   = !out_valid || (out_ready && (pop == '0));
	assign run_last  = pop == '0;

	// Pending-block mask.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s2 <= '0;
		end else if (load) begin
			mask_s2 <= hdr.mask;
		end else if (out_valid && out_ready) begin
			mask_s2 <= pop;
		end
	end

	// Item position and neighborhood.
	always_ff @(posedge clk) begin
		if (load) begin
			row_s2 <= hdr.row;
			col_s2 <= hdr.col;
			pix_s2 <= pix;
		end
	end

	// Lowest pending slot goes first.
	always_comb begin
		if (mask_s2[0]) begin
			slot = bu2x_pkg::SLOT_UP_LEFT;
		end else if (mask_s2[1]) begin
			slot = bu2x_pkg::SLOT_LEFT;
		end else if (mask_s2[2]) begin
			slot = bu2x_pkg::SLOT_UP;
		end else begin
			slot = bu2x_pkg::SLOT_SELF;
		end
	end

	// Corner pixels of the selected block, edges replicated.
	always_comb begin
		case (slot)
			bu2x_pkg::SLOT_UP_LEFT: begin
				pa = pix_s2[bu2x_pkg::PIX_PREV_UP];
				pb = pix_s2[bu2x_pkg::PIX_UP];
				pc = pix_s2[bu2x_pkg::PIX_PREV];
				pd = pix_s2[bu2x_pkg::PIX_CUR];
			end
			bu2x_pkg::SLOT_LEFT: begin
				pa = pix_s2[bu2x_pkg::PIX_PREV];
				pb = pix_s2[bu2x_pkg::PIX_CUR];
				pc = pix_s2[bu2x_pkg::PIX_PREV];
				pd = pix_s2[bu2x_pkg::PIX_CUR];
			end
			bu2x_pkg::SLOT_UP: begin
				pa = pix_s2[bu2x_pkg::PIX_UP];
				pb = pix_s2[bu2x_pkg::PIX_UP];
				pc = pix_s2[bu2x_pkg::PIX_CUR];
				pd = pix_s2[bu2x_pkg::PIX_CUR];
			end
			default: begin
				pa = pix_s2[bu2x_pkg::PIX_CUR];
				pb = pix_s2[bu2x_pkg::PIX_CUR];
				pc = pix_s2[bu2x_pkg::PIX_CUR];
				pd = pix_s2[bu2x_pkg::PIX_CUR];
			end
		endcase
	end

	// Averages, truncated toward zero.
	assign sum_ab  = {1'b0, pa} + {1'b0, pb};
	assign sum_ac  = {1'b0, pa} + {1'b0, pc};
	assign sum_all = {2'b00, pa} + {2'b00, pb} + {2'b00, pc} + {2'b00, pd};

	assign top_left     = pa;
	assign top_right    = mode ? sum_ab[PIXEL_BITS:1] : pa;
	assign bottom_left  = mode ? sum_ac[PIXEL_BITS:1] : pa;
	assign bottom_right = mode ? sum_all[PIXEL_BITS+1:2] : pa;

	// Block position relative to the item that caused it.
	assign src_row = slot[0] ? row_s2 : row_s2 - 10'd1;
	assign src_col = slot[1] ? col_s2 : col_s2 - 10'd1;

endmodule

### rtl/bilinear_upscale_2x_unit.sv
// A pixel is registered in stage 1, then loaded into the output stage once that is free.
// Throughput: one pixel per cycle while each pixel completes at most one block and
// out_ready is high; a pixel completing more (right column, bottom row) holds the
// input until its last block goes out, one block per cycle while out_ready is high.
// Reset: counters, neighbor registers and valids clear; registers go to 512, 512,
// bilinear. The line memory is not cleared; what row 0 reads from it goes unused.
module bilinear_upscale_2x_unit #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_index,
	input  logic [bu2x_pkg::CFG_BITS-1:0]       cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [PIXEL_BITS-1:0]               pixel_in,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [bu2x_pkg::CNT_BITS-1:0]       src_row,
	output logic [bu2x_pkg::CNT_BITS-1:0]       src_col,
	output logic [PIXEL_BITS-1:0]               top_left,
	output logic [PIXEL_BITS-1:0]               top_right,
	output logic [PIXEL_BITS-1:0]               bottom_left,
	output logic [PIXEL_BITS-1:0]               bottom_right,
	output logic                                run_last
);

`include "bilinear_upscale_2x_unit_assert.svh"

	logic [bu2x_pkg::CFG_BITS-1:0] width_q, height_q, width_eff, height_eff;
	logic                          mode_q, s2_free, load;
	bu2x_pkg::bu2x_hdr_t           hdr;
	logic [3:0][PIXEL_BITS-1:0]    pix;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd512;
			height_q <= 11'd512;
			mode_q   <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bu2x_pkg::REG_WIDTH:  width_q  <= cfg_data;
				bu2x_pkg::REG_HEIGHT: height_q <= cfg_data;
				bu2x_pkg::REG_MODE:   mode_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Sizes clamped to the supported range; zero acts as one.
	always_comb begin
		if (width_q == '0) begin
			width_eff = 11'd1;
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			width_eff = 11'(MAX_WIDTH);
		end else begin
			width_eff = width_q;
		end
		if (height_q == '0) begin
			height_eff = 11'd1;
		end else if (height_q > bu2x_pkg::MAX_ROWS) begin
			height_eff = bu2x_pkg::MAX_ROWS;
		end else begin
			height_eff = height_q;
		end
	end

	bu2x_ctrl #(
		.MAX_WIDTH (MAX_WIDTH),
		.PIXEL_BITS(PIXEL_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.width_eff (width_eff),
		.height_eff(height_eff),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel_in  (pixel_in),
		.s2_free   (s2_free),
		.load      (load),
		.hdr       (hdr),
		.pix       (pix)
	);

	bu2x_emit #(
		.PIXEL_BITS(PIXEL_BITS)
	) u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.hdr         (hdr),
		.pix         (pix),
		.mode        (mode_q),
		.s2_free     (s2_free),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.src_row     (src_row),
		.src_col     (src_col),
		.top_left    (top_left),
		.top_right   (top_right),
		.bottom_left (bottom_left),
		.bottom_right(bottom_right),
		.run_last    (run_last)
	);

	// The input only stalls behind a pending block.
	`BU2X_ASSERT_NOW(a_stall_has_cause, clk, arst_n, !in_ready, out_valid)
	// A run that is not finished keeps a block on the output.
	`BU2X_ASSERT_NEXT(a_run_continues, clk, arst_n, out_valid && out_ready && !run_last, out_valid)
	// Replication gives four equal pixels.
	`BU2X_ASSERT_NOW(a_replicate, clk, arst_n, out_valid && !mode_q, (top_right == top_left) && (bottom_left == top_left) && (bottom_right == top_left))

endmodule

### bench/bu2x_block_checker.sv
// Scoreboard for the 2x upscaler: watches the register, pixel and block ports.
// Predicts each emitted 2x2 block from its own line memory; needs bu2x_pkg.
module bu2x_block_checker #(
	parameter int LINE_DEPTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [bu2x_pkg::CFG_BITS-1:0] cfg_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [7:0]                    pixel_in,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [bu2x_pkg::CNT_BITS-1:0] src_row,
	input  logic [bu2x_pkg::CNT_BITS-1:0] src_col,
	input  logic [7:0]                    top_left,
	input  logic [7:0]                    top_right,
	input  logic [7:0]                    bottom_left,
	input  logic [7:0]                    bottom_right,
	input  logic                          run_last,
	output int                            pending_count,
	output int                            fail_count
);
	import bu2x_pkg::*;

	typedef struct packed {
		logic [CNT_BITS-1:0] row;
		logic [CNT_BITS-1:0] col;
		logic [7:0]          tl;
		logic [7:0]          tr;
		logic [7:0]          bl;
		logic [7:0]          br;
		logic                last;
	} upscale_block_t;

	// Shadow copies of the registers.
	logic [CFG_BITS-1:0] width_reg;
	logic [CFG_BITS-1:0] height_reg;
	logic                bilinear;

	// Shadow copy of the stage state.
	logic [7:0]          line_mem [LINE_DEPTH];
	logic [7:0]          left_pix;
	logic [7:0]          left_up_pix;
	logic [CNT_BITS-1:0] col_pos;
	logic [CNT_BITS-1:0] row_pos;

	upscale_block_t expected_blocks [$];

	// One 2x2 block from its four source pixels, averaged or replicated.
	function automatic upscale_block_t make_block(input int row, input int col,
		input int a, input int b, input int c, input int d);
		upscale_block_t blk;
		blk.row  = CNT_BITS'(row);
		blk.col  = CNT_BITS'(col);
		blk.tl   = 8'(a);
		blk.tr   = bilinear ? 8'((a + b) >> 1) : 8'(a);
		blk.bl   = bilinear ? 8'((a + c) >> 1) : 8'(a);
		blk.br   = bilinear ? 8'((a + b + c + d) >> 2) : 8'(a);
		blk.last = 1'b0;
		return blk;
	endfunction

	// Queues the blocks that one source pixel completes and advances the raster.
	function automatic void interpolate_pixel(input logic [7:0] px);
		upscale_block_t blocks [4];
		int n;
		int w;
		int h;
		int col;
		int row;
		int above;
		bit last_col;
		bit last_row;
		n = 0;
		w = int'(width_reg);
		h = int'(height_reg);
		col = int'(col_pos);
		row = int'(row_pos);
		if (w == 0) w = 1;
		if (w > LINE_DEPTH) w = LINE_DEPTH;
		if (h == 0) h = 1;
		if (h > int'(MAX_ROWS)) h = int'(MAX_ROWS);
		last_col = (col + 1 >= w);
		last_row = (row + 1 >= h);
		above = int'(line_mem[col]);

		// Blocks come out by column, upper row first.
		if (row >= 1 && col >= 1) begin
			blocks[n] = make_block(row - 1, col - 1, left_up_pix, above, left_pix, px);
			n++;
		end
		if (last_row && col >= 1) begin
			blocks[n] = make_block(row, col - 1, left_pix, px, left_pix, px);
			n++;
		end
		if (last_col && row >= 1) begin
			blocks[n] = make_block(row - 1, col, above, above, px, px);
			n++;
		end
		if (last_col && last_row) begin
			blocks[n] = make_block(row, col, px, px, px, px);
			n++;
		end
		for (int i = 0; i < n; i++) begin
			blocks[i].last = (i == n - 1);
			expected_blocks.push_back(blocks[i]);
		end

		line_mem[col] = px;
		left_up_pix = 8'(above);
		left_pix = px;
		if (last_col) begin
			col_pos = '0;
			row_pos = last_row ? '0 : CNT_BITS'(row + 1);
		end else begin
			col_pos = CNT_BITS'(col + 1);
		end
	endfunction

	function automatic void compare_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// Register writes, accepted pixels and accepted blocks, sampled at the edge.
	always @(posedge clk or negedge arst_n) begin : monitor
		upscale_block_t want;
		if (!arst_n) begin
			width_reg = CFG_BITS'(512);
			height_reg = CFG_BITS'(512);
			bilinear = 1'b1;
			left_pix = '0;
			left_up_pix = '0;
			col_pos = '0;
			row_pos = '0;
			expected_blocks.delete();
			pending_count = 0;
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_WIDTH:  width_reg = cfg_data;
					REG_HEIGHT: height_reg = cfg_data;
					REG_MODE:   bilinear = cfg_data[0];
					default:    ;
				endcase
			end
			if (in_valid && in_ready)
				interpolate_pixel(pixel_in);
			if (out_valid && out_ready) begin
				if (expected_blocks.size() == 0) begin
					$error("block at row %0d col %0d arrived with none expected",
						src_row, src_col);
					fail_count++;
				end else begin
					want = expected_blocks.pop_front();
					compare_field("src_row", want.row, src_row);
					compare_field("src_col", want.col, src_col);
					compare_field("top_left", want.tl, top_left);
					compare_field("top_right", want.tr, top_right);
					compare_field("bottom_left", want.bl, bottom_left);
					compare_field("bottom_right", want.br, bottom_right);
					compare_field("run_last", want.last, run_last);
				end
			end
			pending_count = expected_blocks.size();
		end
	end

endmodule

### bench/testbench.sv
// Top of the 2x upscaler bench: clock, reset, pixel stimulus and output back-pressure.
// Instantiates bilinear_upscale_2x_unit and bu2x_block_checker; needs bu2x_pkg.
module testbench;
	import bu2x_pkg::*;

	localparam int RANDOM_ITEMS  = 270;
	localparam int CALM_ITEMS    = 60;
	localparam int LONG_HOLD     = 64;
	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 6;
	localparam int TAIL_CYCLES   = 8;
	localparam int SEGMENT_MAX   = 96;
	localparam int FULL_SIZE     = 1024;
	localparam int PRIME_WIDTH   = 64;
	localparam int TALL_ROWS     = 96;

	// Index with no register behind it; writes to it must change nothing.
	localparam logic [1:0] REG_SPARE = 2'd3;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [1:0]          cfg_index;
	logic [CFG_BITS-1:0] cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic [7:0]          pixel_in;
	logic                out_valid;
	logic                out_ready;
	logic [CNT_BITS-1:0] src_row;
	logic [CNT_BITS-1:0] src_col;
	logic [7:0]          top_left;
	logic [7:0]          top_right;
	logic [7:0]          bottom_left;
	logic [7:0]          bottom_right;
	logic                run_last;

	int pending_count;
	int fail_count;
	bit calm;
	int hold_requests;
	int holds_served;

	bilinear_upscale_2x_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel_in     (pixel_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.src_row      (src_row),
		.src_col      (src_col),
		.top_left     (top_left),
		.top_right    (top_right),
		.bottom_left  (bottom_left),
		.bottom_right (bottom_right),
		.run_last     (run_last)
	);

	bu2x_block_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.pixel_in      (pixel_in),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.src_row       (src_row),
		.src_col       (src_col),
		.top_left      (top_left),
		.top_right     (top_right),
		.bottom_left   (bottom_left),
		.bottom_right  (bottom_right),
		.run_last      (run_last),
		.pending_count (pending_count),
		.fail_count    (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Block sink: random stall bursts, one long hold-off on request, none at the end.
	initial begin : block_sink
		int stall_left;
		stall_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_served != hold_requests) begin
				out_ready = 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				holds_served++;
			end else if (calm) begin
				out_ready = 1'b1;
			end else if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else if ($urandom_range(0, 5) == 0) begin
				out_ready = 1'b0;
				stall_left = $urandom_range(1, 7) - 1;
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// Ends the run when neither channel has moved an item for too long.
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("** bilinear_upscale_2x_unit: FAILED **");
		$finish;
	end

	task automatic write_reg(input logic [1:0] idx, input int unsigned value);
		cfg_index = idx;
		cfg_data = CFG_BITS'(value);
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_image(input int unsigned w, input int unsigned h, input bit mode);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_MODE, mode);
	endtask

	// Stops offering pixels until every block is out and the pipeline is quiet.
	task automatic settle();
		in_valid = 1'b0;
		wait (pending_count == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Offers one pixel, maybe after a gap, and returns at the falling edge after it is taken.
	task automatic send_pixel(input logic [7:0] px);
		if (!calm && $urandom_range(0, 7) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		pixel_in = px;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [7:0] random_pixel();
		if ($urandom_range(0, 7) == 0)
			return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
		return 8'($urandom_range(0, 255));
	endfunction

	// Mostly small image sizes, with zero, medium and oversize now and then.
	// Widths never go oversize, so the column stays within the primed entries.
	function automatic int unsigned pick_size(input bit allow_over);
		case ($urandom_range(0, 19))
			0:       return 0;
			1:       return allow_over ? $urandom_range(FULL_SIZE + 1, 2047)
				: $urandom_range(13, 40);
			2, 3:    return $urandom_range(13, 40);
			default: return $urandom_range(1, 12);
		endcase
	endfunction

	function automatic int clamp_size(input int unsigned v);
		if (v == 0)
			return 1;
		return (v > FULL_SIZE) ? FULL_SIZE : int'(v);
	endfunction

	initial begin : stimulus
		int sent;
		int len;
		int frame;
		int unsigned w;
		int unsigned h;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_WIDTH;
		cfg_data = '0;
		in_valid = 1'b0;
		pixel_in = '0;
		calm = 1'b0;
		hold_requests = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// One row first at zero height. Every line entry that later images can
		// reach is written here, so mid-frame widening reads known data.
		set_image(PRIME_WIDTH, 0, 1'b1);
		for (int i = 0; i < PRIME_WIDTH; i++)
			send_pixel((i < 8) ? ((i % 2 != 0) ? 8'hFF : 8'h00) : random_pixel());

		// Spare-register write, then small directed images: all-max pixels, replication, single pixel, 2x3.
		settle();
		write_reg(REG_SPARE, 11'h7FF);
		set_image(2, 2, 1'b1);
		repeat (4) send_pixel(8'hFF);
		settle();
		set_image(3, 2, 1'b0);
		send_pixel(8'h00);
		send_pixel(8'hFF);
		send_pixel(8'h11);
		send_pixel(8'hC8);
		send_pixel(8'h01);
		send_pixel(8'h80);
		settle();
		set_image(1, 1, 1'b1);
		send_pixel(8'hFF);
		send_pixel(8'h00);
		settle();
		set_image(2, 3, 1'b1);
		for (int i = 0; i < 6; i++)
			send_pixel(((i % 3) == 0) ? 8'h00 : 8'hFF);

		// Shrink the width mid-row: the column counter lands past the new edge.
		settle();
		set_image(4, 2, 1'b1);
		send_pixel(8'h10);
		send_pixel(8'hF0);
		send_pixel(8'h7F);
		settle();
		write_reg(REG_WIDTH, 2);
		send_pixel(8'h80);
		send_pixel(8'hFE);
		send_pixel(8'h01);

		// Oversize height, one column wide, with the sink held off at the start
		// so the stage backs up; halfway the source drains and the mode flips.
		settle();
		set_image(0, 2047, 1'b1);
		hold_requests++;
		for (int i = 0; i < TALL_ROWS; i++) begin
			if (i == TALL_ROWS / 2) begin
				settle();
				write_reg(REG_MODE, 0);
			end
			send_pixel(random_pixel());
		end

		// Random segments: whole frames or partial ones followed by new sizes.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			settle();
			w = pick_size(1'b0);
			h = pick_size(1'b1);
			set_image(w, h, 1'($urandom_range(0, 1)));
			frame = clamp_size(w) * clamp_size(h);
			if (frame > SEGMENT_MAX)
				len = $urandom_range(1, SEGMENT_MAX);
			else if ($urandom_range(0, 2) != 0)
				len = frame;
			else
				len = $urandom_range(1, 2 * frame);
			for (int i = 0; i < len && sent < RANDOM_ITEMS; i++) begin
				calm = (sent >= RANDOM_ITEMS - CALM_ITEMS);
				send_pixel(random_pixel());
				sent++;
			end
		end
		in_valid = 1'b0;

		wait (pending_count == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("** bilinear_upscale_2x_unit: PASSED **");
		else
			$display("** bilinear_upscale_2x_unit: FAILED **");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl
rtl/bu2x_pkg.sv
rtl/bu2x_ram.sv
rtl/bu2x_ctrl.sv
rtl/bu2x_emit.sv
rtl/bilinear_upscale_2x_unit.sv
bench/bu2x_block_checker.sv
bench/testbench.sv
